[rtl/fgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgb_pkg
// Types and codes shared by the glyph line blitter modules.
// ----------------------------------------------------------------------------
package fgb_pkg;

   localparam logic [2:0] REQ_MAP_WR     = 3'd0;
   localparam logic [2:0] REQ_GLYPH_WR   = 3'd1;
   localparam logic [2:0] REQ_SET_CURSOR = 3'd2;
   localparam logic [2:0] REQ_DRAW       = 3'd3;
   localparam logic [2:0] REQ_BYTE_WR    = 3'd4;
   localparam logic [2:0] REQ_BYTE_RD    = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_NEG     = 3'd2;
   localparam logic [2:0] ST_HIGH    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;
   localparam logic [2:0] ST_MISSING = 3'd5;
   localparam logic [2:0] ST_BADADDR = 3'd6;

   localparam logic [2:0] CSR_GLYPH_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_GLYPH_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_CODE_COUNT   = 3'd2;
   localparam logic [2:0] CSR_GLYPH_COUNT  = 3'd3;
   localparam logic [2:0] CSR_LINE_BYTES   = 3'd4;

   localparam logic [8:0] MAP_EMPTY = 9'h100;
   localparam int ROW_BYTES = 5;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [15:0] char_code;
      logic [7:0]         glyph_index;
      logic               glyph_empty;
      logic [4:0]         row;
      logic [31:0]        row_bits;
      logic [7:0]         byte_column;
      logic [7:0]         byte_data;
      logic [10:0]        cursor_value;
   } fgb_req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_data;
      logic [10:0] cursor_now;
   } fgb_rsp_item_type;

   typedef struct packed {
      logic [5:0] glyph_width;
      logic [5:0] glyph_height;
      logic [8:0] code_count;
      logic [8:0] glyph_count;
      logic [8:0] line_bytes;
   } fgb_cfg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_READ_WAIT,
      S_MAP_WAIT,
      S_GLYPH_RD,
      S_GLYPH_WAIT,
      S_BAND_RD,
      S_BAND_WAIT
   } fgb_state_type;

endpackage

[rtl/fgb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgb_ram
// Simple dual-port synchronous RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module fgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fgb_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgb_csr
// Configuration registers on the APB port, with read back and range caps.
// ----------------------------------------------------------------------------
module fgb_csr import fgb_pkg::*; #(
   parameter int MAX_CODES      = 256,
   parameter int MAX_GLYPHS     = 256,
   parameter int MAX_GLYPH_W    = 32,
   parameter int MAX_GLYPH_H    = 32,
   parameter int MAX_LINE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output fgb_cfg_type cfg
);

   localparam int WIDTH_CAP = (MAX_GLYPH_W < 32) ? MAX_GLYPH_W : 32;

   fgb_cfg_type raw_ff;
   fgb_cfg_type raw_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      raw_in = raw_ff;
      if (wr_en) begin
         case (paddr[4:2])
            CSR_GLYPH_WIDTH:  raw_in.glyph_width  = pwdata[5:0];
            CSR_GLYPH_HEIGHT: raw_in.glyph_height = pwdata[5:0];
            CSR_CODE_COUNT:   raw_in.code_count   = pwdata[8:0];
            CSR_GLYPH_COUNT:  raw_in.glyph_count  = pwdata[8:0];
            CSR_LINE_BYTES:   raw_in.line_bytes   = pwdata[8:0];
            default:          raw_in = raw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff.glyph_width  <= 6'd8;
         raw_ff.glyph_height <= 6'd8;
         raw_ff.code_count   <= 9'd0;
         raw_ff.glyph_count  <= 9'd0;
         raw_ff.line_bytes   <= 9'd256;
      end else begin
         raw_ff <= raw_in;
      end
   end

   always_comb begin
      case (paddr[4:2])
         CSR_GLYPH_WIDTH:  prdata = 32'(raw_ff.glyph_width);
         CSR_GLYPH_HEIGHT: prdata = 32'(raw_ff.glyph_height);
         CSR_CODE_COUNT:   prdata = 32'(raw_ff.code_count);
         CSR_GLYPH_COUNT:  prdata = 32'(raw_ff.glyph_count);
         CSR_LINE_BYTES:   prdata = 32'(raw_ff.line_bytes);
         default:          prdata = 32'd0;
      endcase
   end

   always_comb begin
      cfg.glyph_width  = (32'(raw_ff.glyph_width) > WIDTH_CAP) ?
                         6'(WIDTH_CAP) : raw_ff.glyph_width;
      cfg.glyph_height = (32'(raw_ff.glyph_height) > MAX_GLYPH_H) ?
                         6'(MAX_GLYPH_H) : raw_ff.glyph_height;
      cfg.code_count   = (32'(raw_ff.code_count) > MAX_CODES) ?
                         9'(MAX_CODES) : raw_ff.code_count;
      cfg.glyph_count  = (32'(raw_ff.glyph_count) > MAX_GLYPHS) ?
                         9'(MAX_GLYPHS) : raw_ff.glyph_count;
      cfg.line_bytes   = (32'(raw_ff.line_bytes) > MAX_LINE_BYTES) ?
                         9'(MAX_LINE_BYTES) : raw_ff.line_bytes;
   end

endmodule

[rtl/fgb_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgb_engine
// Request sequencer around the code map, glyph store and band buffer RAMs.
// ----------------------------------------------------------------------------
module fgb_engine import fgb_pkg::*; #(
   parameter int MAX_CODES      = 256,
   parameter int MAX_GLYPHS     = 256,
   parameter int MAX_GLYPH_H    = 32,
   parameter int MAX_LINE_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  fgb_cfg_type      cfg,
   input  logic             start,
   input  fgb_req_item_type req,
   output logic             busy,
   output logic             rsp_strobe,
   output fgb_rsp_item_type rsp
);

   localparam int CA = $clog2(MAX_CODES);
   localparam int GD = MAX_GLYPHS * MAX_GLYPH_H;
   localparam int GA = $clog2(GD);
   localparam int BD = MAX_GLYPH_H * MAX_LINE_BYTES;
   localparam int BA = $clog2(BD);
   localparam int RW = $clog2(MAX_GLYPH_H) + 1;

   fgb_state_type    state_ff, state_in;
   fgb_req_item_type req_ff, req_in;
   logic [10:0]      cursor_ff, cursor_in;
   logic [CA-1:0]    clr_ff, clr_in;
   logic [7:0]       g_ff, g_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [2:0]       k_ff, k_in;
   logic [39:0]      win_ff, win_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   fgb_rsp_item_type rsp_ff, rsp_in;

   logic          map_we, map_re;
   logic [CA-1:0] map_waddr, map_raddr;
   logic [8:0]    map_wdata, map_rdata;
   logic          glyph_we, glyph_re;
   logic [GA-1:0] glyph_waddr, glyph_raddr;
   logic [31:0]   glyph_rdata;
   logic          band_we, band_re;
   logic [BA-1:0] band_waddr, band_raddr;
   logic [7:0]    band_wdata, band_rdata;

   logic          code_neg;
   logic [15:0]   code_u;
   logic          line_full;
   logic          band_ok;
   logic [BA-1:0] host_band_addr;
   logic [8:0]    draw_col;
   logic [BA-1:0] draw_band_addr;
   logic [31:0]   row_mask;

   fgb_ram #(.WIDTH(9), .DEPTH(MAX_CODES)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_en(map_re), .rd_addr(map_raddr), .rd_data(map_rdata)
   );

   fgb_ram #(.WIDTH(32), .DEPTH(GD)) u_glyph (
      .clock(clock), .wr_en(glyph_we), .wr_addr(glyph_waddr),
      .wr_data(req_ff.row_bits), .rd_en(glyph_re), .rd_addr(glyph_raddr),
      .rd_data(glyph_rdata)
   );

   fgb_ram #(.WIDTH(8), .DEPTH(BD)) u_band (
      .clock(clock), .wr_en(band_we), .wr_addr(band_waddr), .wr_data(band_wdata),
      .rd_en(band_re), .rd_addr(band_raddr), .rd_data(band_rdata)
   );

   assign code_neg  = req_ff.char_code[15];
   assign code_u    = req_ff.char_code;
   assign line_full = ({1'b0, cursor_ff} + 12'(cfg.glyph_width)) >=
                      {cfg.line_bytes, 3'b000};
   assign band_ok   = (32'(req_ff.row) < MAX_GLYPH_H) &&
                      (9'(req_ff.byte_column) < cfg.line_bytes);
   assign host_band_addr = BA'(32'(req_ff.row) * MAX_LINE_BYTES +
                               32'(req_ff.byte_column));
   assign draw_col       = 9'(cursor_ff[10:3]) + 9'(k_ff);
   assign draw_band_addr = BA'(32'(r_ff) * MAX_LINE_BYTES + 32'(draw_col));
   assign row_mask       = ~(32'hFFFF_FFFF >> cfg.glyph_width);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cursor_in     = cursor_ff;
      clr_in        = clr_ff;
      g_in          = g_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      win_in        = win_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      map_we        = 1'b0;
      map_waddr     = CA'(code_u);
      map_wdata     = req_ff.glyph_empty ? MAP_EMPTY : {1'b0, req_ff.glyph_index};
      map_re        = 1'b0;
      map_raddr     = CA'(code_u);
      glyph_we      = 1'b0;
      glyph_waddr   = GA'(32'(req_ff.glyph_index) * MAX_GLYPH_H + 32'(req_ff.row));
      glyph_re      = 1'b0;
      glyph_raddr   = GA'(32'(g_ff) * MAX_GLYPH_H + 32'(r_ff));
      band_we       = 1'b0;
      band_waddr    = host_band_addr;
      band_wdata    = req_ff.byte_data;
      band_re       = 1'b0;
      band_raddr    = host_band_addr;

      case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = MAP_EMPTY;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CA'(MAX_CODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in.status     = ST_OK;
            rsp_in.read_data  = 8'd0;
            rsp_in.cursor_now = cursor_ff;
            rsp_strobe_in     = 1'b1;
            state_in          = S_IDLE;
            case (req_ff.req_type)
               REQ_MAP_WR: begin
                  if (code_neg || 32'(code_u) >= MAX_CODES) begin
                     rsp_in.status = ST_BADADDR;
                  end else begin
                     map_we = 1'b1;
                  end
               end
               REQ_GLYPH_WR: begin
                  if (32'(req_ff.glyph_index) >= MAX_GLYPHS ||
                      32'(req_ff.row) >= MAX_GLYPH_H) begin
                     rsp_in.status = ST_BADADDR;
                  end else begin
                     glyph_we = 1'b1;
                  end
               end
               REQ_SET_CURSOR: begin
                  cursor_in         = req_ff.cursor_value;
                  rsp_in.cursor_now = req_ff.cursor_value;
               end
               REQ_DRAW: begin
                  if (line_full) begin
                     rsp_in.status = ST_FULL;
                  end else if (code_neg) begin
                     rsp_in.status = ST_NEG;
                  end else if (code_u >= 16'(cfg.code_count)) begin
                     rsp_in.status = ST_HIGH;
                  end else begin
                     map_re        = 1'b1;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_MAP_WAIT;
                  end
               end
               REQ_BYTE_WR: begin
                  if (!band_ok) begin
                     rsp_in.status = ST_BADADDR;
                  end else begin
                     band_we = 1'b1;
                  end
               end
               REQ_BYTE_RD: begin
                  if (!band_ok) begin
                     rsp_in.status = ST_BADADDR;
                  end else begin
                     band_re       = 1'b1;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_READ_WAIT;
                  end
               end
               default: begin
                  rsp_in.status = ST_BADADDR;
               end
            endcase
         end
         S_READ_WAIT: begin
            rsp_in.read_data = band_rdata;
            rsp_strobe_in    = 1'b1;
            state_in         = S_IDLE;
         end
         S_MAP_WAIT: begin
            if (map_rdata[8]) begin
               rsp_in.status = ST_EMPTY;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (9'(map_rdata[7:0]) >= cfg.glyph_count) begin
               rsp_in.status = ST_MISSING;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               g_in     = map_rdata[7:0];
               r_in     = '0;
               state_in = S_GLYPH_RD;
            end
         end
         S_GLYPH_RD: begin
            if (r_ff == RW'(cfg.glyph_height)) begin
               cursor_in         = cursor_ff + 11'(cfg.glyph_width);
               rsp_in.cursor_now = cursor_ff + 11'(cfg.glyph_width);
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end else begin
               glyph_re = 1'b1;
               state_in = S_GLYPH_WAIT;
            end
         end
         S_GLYPH_WAIT: begin
            win_in   = {glyph_rdata & row_mask, 8'h00} >> cursor_ff[2:0];
            k_in     = '0;
            state_in = S_BAND_RD;
         end
         S_BAND_RD: begin
            band_raddr = draw_band_addr;
            if (k_ff == 3'(ROW_BYTES)) begin
               r_in     = r_ff + 1'b1;
               state_in = S_GLYPH_RD;
            end else if (win_ff[39:32] != 8'h00 && 32'(draw_col) < MAX_LINE_BYTES) begin
               band_re  = 1'b1;
               state_in = S_BAND_WAIT;
            end else begin
               k_in   = k_ff + 1'b1;
               win_in = win_ff << 8;
            end
         end
         S_BAND_WAIT: begin
            band_we    = 1'b1;
            band_waddr = draw_band_addr;
            band_wdata = band_rdata | win_ff[39:32];
            k_in       = k_ff + 1'b1;
            win_in     = win_ff << 8;
            state_in   = S_BAND_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cursor_ff     <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      g_ff   <= g_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      win_ff <= win_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

[rtl/font_glyph_line_blitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_line_blitter
// Glyph renderer into a 1-bit printer band buffer, APB configured.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on rsp_data for one cycle with rsp_strobe and must be taken then.
// After reset the block is busy while it marks every code map entry empty.
// Map, glyph row, cursor and byte writes finish in the execute state; a byte
// read then waits for the band buffer RAM. A draw that fails the line, sign
// or range checks ends in the execute state, and one that fails on the map
// entry ends after the map read. Otherwise the draw checks, then for each of
// glyph_height rows reads the glyph row and walks 5 byte slots, and each band
// byte touched is a read then a write through the single read port of the
// band buffer RAM.
module font_glyph_line_blitter import fgb_pkg::*; #(
   parameter int MAX_CODES      = 256,
   parameter int MAX_GLYPHS     = 256,
   parameter int MAX_GLYPH_W    = 32,
   parameter int MAX_GLYPH_H    = 32,
   parameter int MAX_LINE_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  fgb_req_item_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output fgb_rsp_item_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   fgb_cfg_type cfg;

   fgb_csr #(
      .MAX_CODES(MAX_CODES), .MAX_GLYPHS(MAX_GLYPHS), .MAX_GLYPH_W(MAX_GLYPH_W),
      .MAX_GLYPH_H(MAX_GLYPH_H), .MAX_LINE_BYTES(MAX_LINE_BYTES)
   ) u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   fgb_engine #(
      .MAX_CODES(MAX_CODES), .MAX_GLYPHS(MAX_GLYPHS),
      .MAX_GLYPH_H(MAX_GLYPH_H), .MAX_LINE_BYTES(MAX_LINE_BYTES)
   ) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg), .start(start), .req(req_data),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );

endmodule

[rtl/fgb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgb_checker
// Port-level checks on the glyph line blitter, bound to the top level.
// ----------------------------------------------------------------------------
module fgb_checker import fgb_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input fgb_rsp_item_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in a row");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status <= ST_BADADDR))
      else $error("status code out of range");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.read_data == 8'd0))
      else $error("read data nonzero on failed request");

endmodule

bind font_glyph_line_blitter fgb_checker u_fgb_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);

[tb/sv/font_glyph_line_blitter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_line_blitter_tb
// Self-checking bench for the glyph line blitter.
// ----------------------------------------------------------------------------
// Preloads the glyph rows and band bytes that the stimulus can reach, then
// runs directed requests and random phases under several register settings.
// A local model of the map, glyph store, band buffer and cursor predicts
// every status, read byte and cursor; each result beat is compared against
// the oldest prediction.
// ----------------------------------------------------------------------------
module font_glyph_line_blitter_tb;
   import fgb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   fgb_req_item_type req_data = '0;
   logic busy;
   logic rsp_strobe;
   fgb_rsp_item_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   font_glyph_line_blitter dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // local copy of block state
   logic [5:0]  cfg_width = 6'd8;
   logic [5:0]  cfg_height = 6'd8;
   logic [8:0]  cfg_codes = 9'd0;
   logic [8:0]  cfg_glyphs = 9'd0;
   logic [8:0]  cfg_line = 9'd256;
   logic [8:0]  map_model [256];
   logic [31:0] glyph_model [8192];
   logic [7:0]  band_model [8192];
   logic [10:0] cursor_model = '0;

   fgb_req_item_type pending_reqs [$];
   fgb_rsp_item_type expected_rsps [$];
   int gap_left = 0;
   bit gaps_on = 1'b0;
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int draws_ok = 0;

   function automatic fgb_rsp_item_type blit_predict(fgb_req_item_type r);
      fgb_rsp_item_type o;
      int code;
      int unsigned w, h, lb, g, pos, bits;
      logic [8:0] entry;
      bit band_ok;
      code = r.char_code;
      o = '0;
      o.status = ST_OK;
      w = (cfg_width > 32) ? 32 : cfg_width;
      h = (cfg_height > 32) ? 32 : cfg_height;
      lb = (cfg_line > 256) ? 256 : cfg_line;
      band_ok = (r.byte_column < lb);
      case (r.req_type)
         REQ_MAP_WR: begin
            if (code < 0 || code >= 256) o.status = ST_BADADDR;
            else map_model[code] = r.glyph_empty ? MAP_EMPTY : {1'b0, r.glyph_index};
         end
         REQ_GLYPH_WR: glyph_model[{r.glyph_index, r.row}] = r.row_bits;
         REQ_SET_CURSOR: cursor_model = r.cursor_value;
         REQ_DRAW: begin
            entry = map_model[code[7:0]];
            if (w + cursor_model >= lb * 8) o.status = ST_FULL;
            else if (code < 0) o.status = ST_NEG;
            else if (code >= ((cfg_codes > 256) ? 256 : cfg_codes)) o.status = ST_HIGH;
            else if (entry[8]) o.status = ST_EMPTY;
            else if (entry[7:0] >= ((cfg_glyphs > 256) ? 256 : cfg_glyphs))
               o.status = ST_MISSING;
            else begin
               g = entry[7:0];
               for (int y = 0; y < h; y++) begin
                  bits = glyph_model[g * 32 + y];
                  for (int x = 0; x < w; x++) begin
                     if (bits[31 - x]) begin
                        pos = cursor_model + x;
                        if ((pos >> 3) < 256)
                           band_model[y * 256 + (pos >> 3)] |= 8'h80 >> (pos & 7);
                     end
                  end
               end
               cursor_model = cursor_model + w[10:0];
            end
         end
         REQ_BYTE_WR: begin
            if (!band_ok) o.status = ST_BADADDR;
            else band_model[{r.row, r.byte_column}] = r.byte_data;
         end
         REQ_BYTE_RD: begin
            if (!band_ok) o.status = ST_BADADDR;
            else o.read_data = band_model[{r.row, r.byte_column}];
         end
         default: o.status = ST_BADADDR;
      endcase
      o.cursor_now = cursor_model;
      return o;
   endfunction

   task automatic report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(blit_predict(req_data));
            beats_in++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               start <= 1'b1;
               gap_left <= gaps_on ? $urandom_range(0, 17) : 0;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fgb_rsp_item_type e;
      if (!reset && rsp_strobe) begin
         beats_out++;
         if (expected_rsps.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status)
               report($sformatf("status %0d, want %0d", rsp_data.status, e.status));
            if (rsp_data.read_data !== e.read_data)
               report($sformatf("read_data %h, want %h", rsp_data.read_data, e.read_data));
            if (rsp_data.cursor_now !== e.cursor_now)
               report($sformatf("cursor %0d, want %0d", rsp_data.cursor_now, e.cursor_now));
            if (e.status == ST_OK && rsp_data.status == ST_OK) draws_ok++;
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_GLYPH_WIDTH:  cfg_width = value[5:0];
         CSR_GLYPH_HEIGHT: cfg_height = value[5:0];
         CSR_CODE_COUNT:   cfg_codes = value[8:0];
         CSR_GLYPH_COUNT:  cfg_glyphs = value[8:0];
         CSR_LINE_BYTES:   cfg_line = value[8:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int w, int h, int cc, int gc, int lb);
      csr_write(CSR_GLYPH_WIDTH, w);
      csr_write(CSR_GLYPH_HEIGHT, h);
      csr_write(CSR_CODE_COUNT, cc);
      csr_write(CSR_GLYPH_COUNT, gc);
      csr_write(CSR_LINE_BYTES, lb);
   endtask

   function automatic fgb_req_item_type make_req(logic [2:0] kind);
      fgb_req_item_type r;
      r = 92'({$urandom, $urandom, $urandom});
      r.req_type = kind;
      return r;
   endfunction

   // map entries only name preloaded glyphs; band reads stay in preloaded columns
   function automatic fgb_req_item_type random_req();
      fgb_req_item_type r;
      int unsigned pick, lb, lb8;
      pick = $urandom_range(0, 99);
      if (pick < 12) r = make_req(REQ_MAP_WR);
      else if (pick < 20) r = make_req(REQ_GLYPH_WR);
      else if (pick < 30) r = make_req(REQ_SET_CURSOR);
      else if (pick < 70) r = make_req(REQ_DRAW);
      else if (pick < 80) r = make_req(REQ_BYTE_WR);
      else if (pick < 96) r = make_req(REQ_BYTE_RD);
      else r = make_req(3'($urandom_range(6, 7)));
      if ($urandom_range(0, 7) != 0) r.char_code = 16'($urandom_range(0, 280));
      if (r.req_type == REQ_MAP_WR) begin
         r.glyph_empty = ($urandom_range(0, 7) == 0);
         r.glyph_index = 8'($urandom_range(0, 3));
      end
      lb = (cfg_line > 256) ? 256 : cfg_line;
      lb8 = lb * 8;
      if (r.req_type == REQ_SET_CURSOR && lb8 > 0 && $urandom_range(0, 3) != 0)
         r.cursor_value = 11'($urandom_range(0, lb8 - 1));
      if (r.req_type >= REQ_BYTE_WR && lb > 0 && $urandom_range(0, 3) != 0)
         r.byte_column = 8'($urandom_range(0, lb - 1));
      if (r.req_type == REQ_BYTE_RD && lb > 8)
         r.byte_column = 8'($urandom_range(0, 7));
      return r;
   endfunction

   task automatic push_req(logic [2:0] kind, int code, int gidx, int rw, int col, int val);
      fgb_req_item_type r;
      r = make_req(kind);
      r.char_code = 16'(code);
      r.glyph_index = 8'(gidx);
      r.glyph_empty = (val < 0);
      r.row = 5'(rw);
      r.byte_column = 8'(col);
      r.byte_data = 8'(val);
      r.cursor_value = 11'(val);
      pending_reqs.push_back(r);
   endtask

   initial begin
      int phase_w [8] = '{32, 1, 0, 63, 63, 8, 12, 32};
      int phase_h [8] = '{32, 1, 0, 63, 63, 8, 16, 5};
      int phase_c [8] = '{256, 256, 256, 0, 511, 64, 300, 0};
      int phase_g [8] = '{256, 2, 256, 511, 511, 3, 1, 256};
      int phase_l [8] = '{8, 3, 0, 511, 8, 5, 7, 1};
      fgb_req_item_type r;
      for (int i = 0; i < 256; i++) map_model[i] = MAP_EMPTY;
      for (int i = 0; i < 8192; i++) begin
         glyph_model[i] = '0;
         band_model[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // preload glyphs 0 to 3 and band columns 0 to 7 of every row
      for (int i = 0; i < 128; i++) begin
         r = make_req(REQ_GLYPH_WR);
         r.glyph_index = 8'(i >> 5);
         r.row = i[4:0];
         pending_reqs.push_back(r);
      end
      for (int i = 0; i < 256; i++) begin
         r = make_req(REQ_BYTE_WR);
         r.row = i[7:3];
         r.byte_column = {5'd0, i[2:0]};
         if ($urandom_range(0, 1)) r.byte_data = 8'h00;
         pending_reqs.push_back(r);
      end
      drain();
      gaps_on = 1'b1;

      // directed
      set_config(8, 8, 256, 100, 256);
      push_req(REQ_MAP_WR, 0, 0, 0, 0, 0);
      push_req(REQ_MAP_WR, 1, 0, 0, 0, -1);
      push_req(REQ_MAP_WR, 5, 200, 0, 0, 0);
      push_req(REQ_MAP_WR, 255, 3, 0, 0, 0);
      push_req(REQ_MAP_WR, -1, 3, 0, 0, 0);
      push_req(REQ_MAP_WR, 256, 3, 0, 0, 0);
      push_req(REQ_MAP_WR, -32768, 3, 0, 0, 0);
      push_req(REQ_GLYPH_WR, 0, 255, 31, 0, 0);
      push_req(REQ_DRAW, 0, 0, 0, 0, 0);
      push_req(REQ_DRAW, -5, 0, 0, 0, 0);
      push_req(REQ_DRAW, 32767, 0, 0, 0, 0);
      push_req(REQ_DRAW, 300, 0, 0, 0, 0);
      push_req(REQ_DRAW, 1, 0, 0, 0, 0);
      push_req(REQ_DRAW, 5, 0, 0, 0, 0);
      push_req(REQ_MAP_WR, 5, 2, 0, 0, 0);
      push_req(REQ_SET_CURSOR, 0, 0, 0, 0, 2040);
      push_req(REQ_DRAW, 0, 0, 0, 0, 0);
      push_req(REQ_SET_CURSOR, 0, 0, 0, 0, 2047);
      push_req(REQ_DRAW, 0, 0, 0, 0, 0);
      push_req(REQ_BYTE_WR, 0, 0, 31, 255, 255);
      push_req(REQ_BYTE_RD, 0, 0, 31, 255, 0);
      push_req(REQ_BYTE_RD, 0, 0, 0, 0, 0);
      push_req(3'd6, 0, 0, 0, 0, 0);
      push_req(3'd7, 0, 0, 0, 0, 0);
      drain();

      for (int p = 0; p < 8; p++) begin
         set_config(phase_w[p], phase_h[p], phase_c[p], phase_g[p], phase_l[p]);
         for (int i = 0; i < 36; i++) begin
            gaps_on = (i % 40) < 30;
            pending_reqs.push_back(random_req());
            while (pending_reqs.size() > 4) @(negedge clock);
         end
         drain();
      end

      repeat (200) @(negedge clock);
      $display("Covered %0d request beats, %0d result beats, %0d ok results, 9 settings.",
               beats_in, beats_out, draws_ok);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_rsps.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout with %0d results outstanding", expected_rsps.size());
      $display("Verification failed");
      $finish;
   end

endmodule
